// ===== sv/cpps_pkg.sv =====
// Shared types, widths and constants for the convex polygon plane splitter.
`default_nettype none
package cpps_pkg;

    localparam int unsigned CoordW      = 32;
    localparam int unsigned NormW       = 18;
    localparam int unsigned OffW        = 32;
    localparam int unsigned EpsW        = 16;
    localparam int unsigned ProdW       = NormW + CoordW;
    localparam int unsigned SumW        = ProdW + 2;
    localparam int unsigned FracW       = 16;
    localparam int unsigned DistW       = 48;
    localparam int unsigned TW          = 28;
    localparam int unsigned MagW        = CoordW + 1;
    localparam int unsigned MulW        = MagW + TW;
    localparam int unsigned PDataW      = 32;
    localparam int unsigned PAddrW      = 5;
    localparam int unsigned DefMaxVerts = 16;

    typedef enum logic [1:0] {
        SIDE_FRONT = 2'd0,
        SIDE_BACK  = 2'd1,
        SIDE_ON    = 2'd2
    } t_side;

    typedef enum logic [2:0] {
        REG_NORMAL_X     = 3'd0,
        REG_NORMAL_Y     = 3'd1,
        REG_NORMAL_Z     = 3'd2,
        REG_PLANE_OFFSET = 3'd3,
        REG_EPSILON      = 3'd4
    } t_reg;

    // One stored vertex with its distance and class.
    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] z;
        logic signed [DistW-1:0]  d;
        t_side                    side;
    } t_vert;

    localparam int unsigned VertW = $bits(t_vert);

    localparam logic signed [NormW-1:0] NormPlusOne  = 18'sd65536;
    localparam logic signed [NormW-1:0] NormMinusOne = -18'sd65536;
    localparam logic signed [OffW-1:0]  OffMin       = 32'sh8000_0000;
    localparam logic signed [OffW-1:0]  OffMax       = 32'sh7fff_ffff;

    localparam logic signed [NormW-1:0] RstNormalX = 18'sd65536;
    localparam logic signed [NormW-1:0] RstNormalY = 18'sd0;
    localparam logic signed [NormW-1:0] RstNormalZ = 18'sd0;
    localparam logic signed [OffW-1:0]  RstOffset  = 32'sd0;
    localparam logic [EpsW-1:0]         RstEpsilon = 16'd66;

endpackage
`default_nettype wire

// ===== sv/cpps_ifs.sv =====
// Valid/ready channel interfaces for vertex requests and result requests.
`default_nettype none
interface cpps_vtx_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
    modport source (output valid, x, y, z, last, input ready);
    modport sink   (input valid, x, y, z, last, output ready);
endinterface

interface cpps_res_if;
    logic               valid;
    logic               ready;
    logic               side;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               is_new;
    logic               overflow;
    logic               done_res;
    modport source (output valid, side, out_x, out_y, out_z, is_new, overflow, done_res,
                    input ready);
    modport sink   (input valid, side, out_x, out_y, out_z, is_new, overflow, done_res,
                    output ready);
endinterface
`default_nettype wire

// ===== sv/cpps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cpps_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== sv/cpps_job_fifo.sv =====
// Two-entry queue of finished polygons between the loader and the emitter.
`default_nettype none
module cpps_job_fifo #(
    parameter int unsigned W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic              o_empty,
    output logic      [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    // Pointers and fill level; the loader never holds more than two polygons.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

// ===== sv/cpps_front.sv =====
// Vertex loader: distance pipeline, classification and vertex store writes.
`default_nettype none
module cpps_front #(
    parameter int unsigned MAX_VERTS = cpps_pkg::DefMaxVerts,
    parameter int unsigned IDX_W     = $clog2(MAX_VERTS),
    parameter int unsigned CNT_W     = $clog2(MAX_VERTS + 1)
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [cpps_pkg::CoordW-1:0]  i_x,
    input  wire logic signed [cpps_pkg::CoordW-1:0]  i_y,
    input  wire logic signed [cpps_pkg::CoordW-1:0]  i_z,
    input  wire logic                                i_last,
    input  wire logic signed [cpps_pkg::NormW-1:0]   i_nx,
    input  wire logic signed [cpps_pkg::NormW-1:0]   i_ny,
    input  wire logic signed [cpps_pkg::NormW-1:0]   i_nz,
    input  wire logic signed [cpps_pkg::OffW-1:0]    i_offset,
    input  wire logic        [cpps_pkg::EpsW-1:0]    i_eps,
    output logic                                     o_wr_en,
    output logic             [IDX_W:0]               o_wr_addr,
    output cpps_pkg::t_vert                          o_wr_data,
    output logic                                     o_push,
    output logic             [CNT_W+3:0]             o_job,
    input  wire logic                                i_rel,
    input  wire logic                                i_rel_bank
);
    import cpps_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic             r_wbank;
    logic [1:0]       r_busy;
    logic             w_accept;
    logic             w_drop;

    // Stage A: products.
    logic                     r_a_valid, r_a_store, r_a_last, r_a_bank;
    logic [IDX_W-1:0]         r_a_idx;
    logic [CNT_W-1:0]         r_a_n;
    logic signed [CoordW-1:0] r_a_x, r_a_y, r_a_z;
    logic signed [ProdW-1:0]  r_a_px, r_a_py, r_a_pz;

    // Stage B: dot product.
    logic                     r_b_valid, r_b_store, r_b_last, r_b_bank;
    logic [IDX_W-1:0]         r_b_idx;
    logic [CNT_W-1:0]         r_b_n;
    logic signed [CoordW-1:0] r_b_x, r_b_y, r_b_z;
    logic signed [SumW-1:0]   r_b_sum;

    logic r_fs, r_bs, r_drop;

    logic signed [DistW-1:0] w_d;
    logic signed [DistW-1:0] w_eps;
    t_side                   w_side;
    logic                    w_fs, w_bs, w_dr;

    // A new polygon may only start in a bank the emitter has released.
    assign o_ready  = (r_cnt != '0) || !r_busy[r_wbank];
    assign w_accept = i_valid && o_ready;
    assign w_drop   = (r_cnt == CNT_W'(MAX_VERTS));

    // Vertex counter, bank select and bank ownership.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_wbank <= 1'b0;
            r_busy  <= 2'b00;
        end else begin
            if (w_accept) begin
                if (i_last) begin
                    r_cnt   <= '0;
                    r_wbank <= ~r_wbank;
                end else if (!w_drop) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            for (int b = 0; b < 2; b++) begin
                if (w_accept && (r_cnt == '0) && (r_wbank == 1'(b))) begin
                    r_busy[b] <= 1'b1;
                end else if (i_rel && (i_rel_bank == 1'(b))) begin
                    r_busy[b] <= 1'b0;
                end
            end
        end
    end

    // Distance pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= w_accept;
            r_b_valid <= r_a_valid;
        end
    end

    // Distance pipeline payload.
    always_ff @(posedge i_clk) begin
        r_a_store <= !w_drop;
        r_a_last  <= i_last;
        r_a_bank  <= r_wbank;
        r_a_idx   <= r_cnt[IDX_W-1:0];
        r_a_n     <= w_drop ? r_cnt : r_cnt + CNT_W'(1);
        r_a_x     <= i_x;
        r_a_y     <= i_y;
        r_a_z     <= i_z;
        r_a_px    <= i_nx * i_x;
        r_a_py    <= i_ny * i_y;
        r_a_pz    <= i_nz * i_z;

        r_b_store <= r_a_store;
        r_b_last  <= r_a_last;
        r_b_bank  <= r_a_bank;
        r_b_idx   <= r_a_idx;
        r_b_n     <= r_a_n;
        r_b_x     <= r_a_x;
        r_b_y     <= r_a_y;
        r_b_z     <= r_a_z;
        r_b_sum   <= SumW'(r_a_px) + SumW'(r_a_py) + SumW'(r_a_pz);
    end

    // Distance to the plane and its class.
    always_comb begin
        w_d   = DistW'($signed(r_b_sum[SumW-1:FracW])) - DistW'(i_offset);
        w_eps = $signed(DistW'(i_eps));
        if (w_d > w_eps) begin
            w_side = SIDE_FRONT;
        end else if (w_d < -w_eps) begin
            w_side = SIDE_BACK;
        end else begin
            w_side = SIDE_ON;
        end
        w_fs = r_fs || (r_b_store && (w_side == SIDE_FRONT));
        w_bs = r_bs || (r_b_store && (w_side == SIDE_BACK));
        w_dr = r_drop || !r_b_store;
    end

    // Polygon flags, cleared when the polygon is handed on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs   <= 1'b0;
            r_bs   <= 1'b0;
            r_drop <= 1'b0;
        end else if (r_b_valid) begin
            r_fs   <= w_fs && !r_b_last;
            r_bs   <= w_bs && !r_b_last;
            r_drop <= w_dr && !r_b_last;
        end
    end

    assign o_wr_en        = r_b_valid && r_b_store;
    assign o_wr_addr      = {r_b_bank, r_b_idx};
    assign o_wr_data.x    = r_b_x;
    assign o_wr_data.y    = r_b_y;
    assign o_wr_data.z    = r_b_z;
    assign o_wr_data.d    = w_d;
    assign o_wr_data.side = w_side;
    assign o_push         = r_b_valid && r_b_last;
    assign o_job          = {r_b_bank, r_b_n, w_fs, w_bs, w_dr};
endmodule
`default_nettype wire

// ===== sv/cpps_back.sv =====
// Emitter: walks a stored polygon and sends vertices and crossing points.
`default_nettype none
module cpps_back #(
    parameter int unsigned MAX_VERTS = cpps_pkg::DefMaxVerts,
    parameter int unsigned IDX_W     = $clog2(MAX_VERTS),
    parameter int unsigned CNT_W     = $clog2(MAX_VERTS + 1)
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_empty,
    input  wire logic        [CNT_W+3:0]             i_job,
    output logic                                     o_pop,
    output logic                                     o_rd_en,
    output logic             [IDX_W:0]               o_rd_addr,
    input  wire cpps_pkg::t_vert                     i_rd_data,
    input  wire logic signed [cpps_pkg::NormW-1:0]   i_nx,
    input  wire logic signed [cpps_pkg::NormW-1:0]   i_ny,
    input  wire logic signed [cpps_pkg::NormW-1:0]   i_nz,
    input  wire logic signed [cpps_pkg::OffW-1:0]    i_offset,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic                                     o_side,
    output logic signed      [cpps_pkg::CoordW-1:0]  o_x,
    output logic signed      [cpps_pkg::CoordW-1:0]  o_y,
    output logic signed      [cpps_pkg::CoordW-1:0]  o_z,
    output logic                                     o_new,
    output logic                                     o_ovf,
    output logic                                     o_done,
    output logic                                     o_rel,
    output logic                                     o_rel_bank
);
    import cpps_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_FETCH, S_LOAD, S_OUT0, S_OUT1, S_DIV, S_MUL, S_MID, S_CR0, S_CR1, S_ADV
    } t_state;

    t_state              r_state;
    logic                r_bank, r_whole, r_wside, r_ovf, r_ld_first;
    logic [CNT_W-1:0]    r_n;
    logic [IDX_W-1:0]    r_i, r_fidx;
    t_vert               r_cur, r_nxt, r_first;
    logic [DistW+1:0]    r_rem, r_den;
    logic [TW-1:0]       r_t;
    logic [4:0]          r_bit;
    logic [MagW-1:0]     r_mag [3];
    logic                r_neg [3];
    logic [MulW-1:0]     r_prod [3];
    logic signed [CoordW-1:0] r_mid [3];

    logic                w_free, w_last_i, w_next_last, w_cross, w_emit;
    logic [DistW-1:0]    w_absd;
    logic signed [DistW:0] w_diff;
    logic [DistW:0]      w_den;
    logic [DistW+1:0]    w_rem_sh;
    logic signed [CoordW-1:0] w_p1 [3];
    logic signed [CoordW-1:0] w_p2 [3];
    logic signed [NormW-1:0]  w_nrm [3];
    logic signed [MagW-1:0]   w_dl [3];
    logic [MagW-1:0]          w_off [3];
    logic signed [MagW:0]     w_sum [3];
    logic signed [CoordW-1:0] w_mid [3];
    logic [MulW-1:0]          w_rnd [3];

    assign w_free      = !o_valid || i_ready;
    assign w_last_i    = (CNT_W'(r_i) + CNT_W'(1)) == r_n;
    assign w_next_last = (CNT_W'(r_i) + CNT_W'(2)) == r_n;
    assign w_cross     = (r_nxt.side != SIDE_ON) && (r_nxt.side != r_cur.side);
    assign w_emit      = w_free && (r_state inside {S_OUT0, S_OUT1, S_CR0, S_CR1});
    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign o_rd_en     = (r_state == S_FETCH);
    assign o_rd_addr   = {r_bank, r_fidx};

    // Crossing arithmetic: distance magnitudes, edge deltas and midpoints.
    always_comb begin
        w_absd   = r_cur.d[DistW-1] ? DistW'(-r_cur.d) : DistW'(r_cur.d);
        w_diff   = (DistW+1)'(r_cur.d) - (DistW+1)'(r_nxt.d);
        w_den    = w_diff[DistW] ? (DistW+1)'(-w_diff) : (DistW+1)'(w_diff);
        w_rem_sh = {r_rem[DistW:0], 1'b0};
        w_p1[0] = r_cur.x;  w_p1[1] = r_cur.y;  w_p1[2] = r_cur.z;
        w_p2[0] = r_nxt.x;  w_p2[1] = r_nxt.y;  w_p2[2] = r_nxt.z;
        w_nrm[0] = i_nx;    w_nrm[1] = i_ny;    w_nrm[2] = i_nz;
        for (int a = 0; a < 3; a++) begin
            w_dl[a]  = MagW'(w_p2[a]) - MagW'(w_p1[a]);
            w_rnd[a] = r_prod[a] + MulW'(1 << (TW - 1));
            w_off[a] = w_rnd[a][MulW-1:TW];
            w_sum[a] = r_neg[a] ? (MagW+1)'(w_p1[a]) - $signed({1'b0, w_off[a]})
                                : (MagW+1)'(w_p1[a]) + $signed({1'b0, w_off[a]});
            if (w_nrm[a] == NormPlusOne) begin
                w_mid[a] = i_offset;
            end else if (w_nrm[a] == NormMinusOne) begin
                w_mid[a] = (i_offset == OffMin) ? OffMax : -i_offset;
            end else begin
                w_mid[a] = w_sum[a][CoordW-1:0];
            end
        end
    end

    // Walk sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            o_rel   <= 1'b0;
        end else begin
            o_rel <= (r_state == S_ADV) && w_last_i;
            if (w_emit) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_bank     <= i_job[CNT_W+3];
                        r_n        <= i_job[CNT_W+2:3];
                        r_whole    <= !(i_job[2] && i_job[1]);
                        r_wside    <= !i_job[2];
                        r_ovf      <= i_job[0];
                        r_i        <= '0;
                        r_fidx     <= '0;
                        r_ld_first <= 1'b1;
                        r_state    <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (r_ld_first) begin
                        r_cur      <= i_rd_data;
                        r_first    <= i_rd_data;
                        r_ld_first <= 1'b0;
                        if (r_n == CNT_W'(1)) begin
                            r_nxt   <= i_rd_data;
                            r_state <= S_OUT0;
                        end else begin
                            r_fidx  <= IDX_W'(1);
                            r_state <= S_FETCH;
                        end
                    end else begin
                        r_nxt   <= i_rd_data;
                        r_state <= S_OUT0;
                    end
                end
                S_OUT0: begin
                    if (w_free) begin
                        o_x     <= r_cur.x;
                        o_y     <= r_cur.y;
                        o_z     <= r_cur.z;
                        o_new   <= 1'b0;
                        o_ovf   <= r_ovf;
                        if (r_whole) begin
                            o_side  <= r_wside;
                            o_done  <= w_last_i;
                            r_state <= S_ADV;
                        end else if (r_cur.side == SIDE_ON) begin
                            o_side  <= 1'b0;
                            o_done  <= 1'b0;
                            r_state <= S_OUT1;
                        end else begin
                            o_side <= r_cur.side[0];
                            o_done <= w_last_i && !w_cross;
                            if (w_cross) begin
                                r_rem <= (DistW+2)'(w_absd);
                                r_den <= (DistW+2)'(w_den);
                                r_t   <= '0;
                                r_bit <= '0;
                                for (int a = 0; a < 3; a++) begin
                                    r_neg[a] <= w_dl[a][MagW-1];
                                    r_mag[a] <= w_dl[a][MagW-1] ? MagW'(-w_dl[a])
                                                                : MagW'(w_dl[a]);
                                end
                                r_state <= S_DIV;
                            end else begin
                                r_state <= S_ADV;
                            end
                        end
                    end
                end
                S_OUT1: begin
                    if (w_free) begin
                        o_side  <= 1'b1;
                        o_done  <= w_last_i;
                        r_state <= S_ADV;
                    end
                end
                S_DIV: begin
                    // One quotient bit per cycle.
                    if (w_rem_sh >= r_den) begin
                        r_rem <= w_rem_sh - r_den;
                        r_t   <= {r_t[TW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_sh;
                        r_t   <= {r_t[TW-2:0], 1'b0};
                    end
                    r_bit <= r_bit + 5'd1;
                    if (r_bit == 5'(TW - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    for (int a = 0; a < 3; a++) begin
                        r_prod[a] <= MulW'(r_mag[a]) * MulW'(r_t);
                    end
                    r_state <= S_MID;
                end
                S_MID: begin
                    for (int a = 0; a < 3; a++) begin
                        r_mid[a] <= w_mid[a];
                    end
                    r_state <= S_CR0;
                end
                S_CR0: begin
                    if (w_free) begin
                        o_side  <= 1'b0;
                        o_x     <= r_mid[0];
                        o_y     <= r_mid[1];
                        o_z     <= r_mid[2];
                        o_new   <= 1'b1;
                        o_ovf   <= r_ovf;
                        o_done  <= 1'b0;
                        r_state <= S_CR1;
                    end
                end
                S_CR1: begin
                    if (w_free) begin
                        o_side  <= 1'b1;
                        o_done  <= w_last_i;
                        r_state <= S_ADV;
                    end
                end
                S_ADV: begin
                    if (w_last_i) begin
                        o_rel_bank <= r_bank;
                        r_state    <= S_IDLE;
                    end else begin
                        r_cur <= r_nxt;
                        r_i   <= r_i + IDX_W'(1);
                        if (w_next_last) begin
                            r_nxt   <= r_first;
                            r_state <= S_OUT0;
                        end else begin
                            r_fidx  <= r_i + IDX_W'(2);
                            r_state <= S_FETCH;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/convex_polygon_plane_split_core.sv =====
// Top level of the convex polygon plane splitter.
`default_nettype none
// Splits a convex polygon against the plane set through the APB registers. Vertex requests
// are taken one per cycle once their polygon holds a bank and pass the distance pipeline
// (products, dot product) into a two-bank vertex store, so the next polygon loads while
// the previous one is emitted; a third polygon waits until the emitter frees a bank. After
// the last vertex the emitter walks the stored polygon (store read, result register,
// advance per vertex); each crossing edge adds the 28-step restoring divider, one multiply
// and one rounding stage. Each result request waits in the output register until taken.
module convex_polygon_plane_split_core #(
    parameter int unsigned MAX_VERTS = cpps_pkg::DefMaxVerts
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    cpps_vtx_if.sink                            i_vtx,
    cpps_res_if.source                          o_res,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [cpps_pkg::PAddrW-1:0]    paddr,
    input  wire logic [cpps_pkg::PDataW-1:0]    pwdata,
    output logic      [cpps_pkg::PDataW-1:0]    prdata,
    output logic                                pready
);
    import cpps_pkg::*;

    localparam int unsigned IdxW  = $clog2(MAX_VERTS);
    localparam int unsigned CntW  = $clog2(MAX_VERTS + 1);
    localparam int unsigned JobW  = CntW + 4;
    localparam int unsigned Depth = 2 << IdxW;

    logic signed [NormW-1:0] r_nx, r_ny, r_nz;
    logic signed [OffW-1:0]  r_offset;
    logic [EpsW-1:0]         r_eps;
    t_reg                    w_reg;

    logic            w_wr_en, w_rd_en, w_push, w_pop, w_empty, w_rel, w_rel_bank;
    logic [IdxW:0]   w_wr_addr, w_rd_addr;
    t_vert           w_wr_data, w_rd_data;
    logic [JobW-1:0] w_job_in, w_job_out;

    assign pready = 1'b1;
    assign w_reg  = t_reg'(paddr[PAddrW-1:2]);

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx     <= RstNormalX;
            r_ny     <= RstNormalY;
            r_nz     <= RstNormalZ;
            r_offset <= RstOffset;
            r_eps    <= RstEpsilon;
        end else if (psel && penable && pwrite) begin
            case (w_reg)
                REG_NORMAL_X:     r_nx     <= pwdata[NormW-1:0];
                REG_NORMAL_Y:     r_ny     <= pwdata[NormW-1:0];
                REG_NORMAL_Z:     r_nz     <= pwdata[NormW-1:0];
                REG_PLANE_OFFSET: r_offset <= pwdata[OffW-1:0];
                REG_EPSILON:      r_eps    <= pwdata[EpsW-1:0];
                default: ;
            endcase
        end
    end

    // Configuration register reads.
    always_comb begin
        case (w_reg)
            REG_NORMAL_X:     prdata = PDataW'(r_nx);
            REG_NORMAL_Y:     prdata = PDataW'(r_ny);
            REG_NORMAL_Z:     prdata = PDataW'(r_nz);
            REG_PLANE_OFFSET: prdata = r_offset;
            REG_EPSILON:      prdata = PDataW'(r_eps);
            default:          prdata = '0;
        endcase
    end

    cpps_front #(.MAX_VERTS(MAX_VERTS), .IDX_W(IdxW), .CNT_W(CntW)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_vtx.valid),
        .o_ready    (i_vtx.ready),
        .i_x        (i_vtx.x),
        .i_y        (i_vtx.y),
        .i_z        (i_vtx.z),
        .i_last     (i_vtx.last),
        .i_nx       (r_nx),
        .i_ny       (r_ny),
        .i_nz       (r_nz),
        .i_offset   (r_offset),
        .i_eps      (r_eps),
        .o_wr_en    (w_wr_en),
        .o_wr_addr  (w_wr_addr),
        .o_wr_data  (w_wr_data),
        .o_push     (w_push),
        .o_job      (w_job_in),
        .i_rel      (w_rel),
        .i_rel_bank (w_rel_bank)
    );

    cpps_ram #(.WIDTH(VertW), .DEPTH(Depth)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    cpps_job_fifo #(.W(JobW)) u_jobs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_job_out)
    );

    cpps_back #(.MAX_VERTS(MAX_VERTS), .IDX_W(IdxW), .CNT_W(CntW)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_job      (w_job_out),
        .o_pop      (w_pop),
        .o_rd_en    (w_rd_en),
        .o_rd_addr  (w_rd_addr),
        .i_rd_data  (w_rd_data),
        .i_nx       (r_nx),
        .i_ny       (r_ny),
        .i_nz       (r_nz),
        .i_offset   (r_offset),
        .o_valid    (o_res.valid),
        .i_ready    (o_res.ready),
        .o_side     (o_res.side),
        .o_x        (o_res.out_x),
        .o_y        (o_res.out_y),
        .o_z        (o_res.out_z),
        .o_new      (o_res.is_new),
        .o_ovf      (o_res.overflow),
        .o_done     (o_res.done_res),
        .o_rel      (w_rel),
        .o_rel_bank (w_rel_bank)
    );
endmodule
`default_nettype wire

// ===== sv/cpps_checker.sv =====
// Port-level checks for the splitter and their binding to the top level.
`default_nettype none
module cpps_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        i_ready,
    input wire logic        i_side,
    input wire logic [31:0] i_x,
    input wire logic [31:0] i_y,
    input wire logic [31:0] i_z,
    input wire logic        i_new,
    input wire logic        i_ovf,
    input wire logic        i_done
);
    logic        r_pair;
    logic [31:0] r_px, r_py, r_pz;
    logic        r_mid;
    logic        r_ovf;
    logic        w_take;

    assign w_take = i_valid && i_ready;

    // Track the open crossing pair and the overflow flag of the polygon in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair <= 1'b0;
            r_mid  <= 1'b0;
            r_ovf  <= 1'b0;
        end else if (w_take) begin
            r_pair <= i_new && !i_side;
            r_px   <= i_x;
            r_py   <= i_y;
            r_pz   <= i_z;
            r_mid  <= !i_done;
            r_ovf  <= i_ovf;
        end
    end

    // A stalled result request holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable({i_side, i_x, i_y, i_z, i_new, i_done}))
        else $error("result changed while stalled");

    // The front copy of a crossing point is followed by its back copy.
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && r_pair |-> i_new && i_side && i_x == r_px && i_y == r_py && i_z == r_pz)
        else $error("crossing point not paired");

    // A polygon never ends on the front copy of a crossing point.
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && i_new && !i_side |-> !i_done)
        else $error("polygon ends inside a crossing pair");

    // The overflow flag stays the same across one polygon.
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && r_mid |-> i_ovf == r_ovf)
        else $error("overflow flag changed inside a polygon");
endmodule

bind convex_polygon_plane_split_core cpps_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_side  (o_res.side),
    .i_x     (o_res.out_x),
    .i_y     (o_res.out_y),
    .i_z     (o_res.out_z),
    .i_new   (o_res.is_new),
    .i_ovf   (o_res.overflow),
    .i_done  (o_res.done_res)
);
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the convex polygon plane splitter core.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cpps_pkg::*;

    localparam int unsigned CapVerts   = DefMaxVerts;
    localparam int unsigned CycleLimit = 1000000;
    localparam int unsigned SettleCyc  = 80;

    // One result request as the block should send it.
    typedef struct {
        logic        side;
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] oz;
        logic        is_new;
        logic        overflow;
        logic        done_res;
    } t_split_vtx;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PAddrW-1:0] paddr;
    logic [PDataW-1:0] pwdata;
    logic [PDataW-1:0] prdata;
    logic pready;

    cpps_vtx_if vtx ();
    cpps_res_if res ();

    convex_polygon_plane_split_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx.sink),
        .o_res   (res.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Plane settings as the predictor sees them.
    longint plane_nx, plane_ny, plane_nz, plane_off, plane_eps;

    // Polygon being loaded, in the predictor.
    longint poly_x [CapVerts];
    longint poly_y [CapVerts];
    longint poly_z [CapVerts];
    longint poly_d [CapVerts];
    t_side  poly_s [CapVerts];
    int     poly_n;
    bit     saw_front, saw_back, saw_drop;

    t_split_vtx split_q[$];
    int  mismatches;
    bit  no_idle;
    int  cycles;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Gap length: mostly short, a few long, none while idling is off.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 50) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Crossing coordinate on one axis, snapped where the normal is axial.
    function automatic longint cross_axis(longint nrm, longint p1, longint p2,
                                          longint unsigned t);
        longint delta;
        longint unsigned mag, off;
        if (nrm == 65536) return plane_off;
        if (nrm == -65536) return (plane_off == -64'sd2147483648) ? 64'sd2147483647 : -plane_off;
        delta = p2 - p1;
        mag = (delta < 0) ? -delta : delta;
        off = (mag * t + (64'd1 << 27)) >> 28;
        return (delta < 0) ? p1 - longint'(off) : p1 + longint'(off);
    endfunction

    function automatic void push_split(logic sd, longint x, longint y, longint z, logic nw,
                                       ref t_split_vtx lst[$]);
        t_split_vtx e;
        e.side = sd; e.ox = x[31:0]; e.oy = y[31:0]; e.oz = z[31:0];
        e.is_new = nw; e.overflow = 1'b0; e.done_res = 1'b0;
        lst.insert(lst.size(), e);
    endfunction

    // Predict the effect of one accepted vertex; on the last one, queue the split lists.
    function automatic void split_vertex(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                         logic last);
        longint x, y, z, dot, d, di, dj;
        longint unsigned num, den, t;
        longint mx, my, mz;
        t_side s;
        t_split_vtx lst[$];
        int j;
        x = longint'(signed'(vx)); y = longint'(signed'(vy)); z = longint'(signed'(vz));
        if (poly_n < CapVerts) begin
            dot = plane_nx * x + plane_ny * y + plane_nz * z;
            d = (dot >>> 16) - plane_off;
            if (d > plane_eps) s = SIDE_FRONT;
            else if (d < -plane_eps) s = SIDE_BACK;
            else s = SIDE_ON;
            poly_x[poly_n] = x; poly_y[poly_n] = y; poly_z[poly_n] = z;
            poly_d[poly_n] = d; poly_s[poly_n] = s;
            if (s == SIDE_FRONT) saw_front = 1'b1;
            if (s == SIDE_BACK) saw_back = 1'b1;
            poly_n++;
        end else begin
            saw_drop = 1'b1;
        end
        if (!last) return;
        if (!saw_front || !saw_back) begin
            // Whole polygon on one side; on-only polygons go to back.
            for (int i = 0; i < poly_n; i++)
                push_split(saw_front ? 1'b0 : 1'b1, poly_x[i], poly_y[i], poly_z[i], 1'b0, lst);
        end else begin
            for (int i = 0; i < poly_n; i++) begin
                j = (i + 1 == poly_n) ? 0 : i + 1;
                if (poly_s[i] == SIDE_ON) begin
                    push_split(1'b0, poly_x[i], poly_y[i], poly_z[i], 1'b0, lst);
                    push_split(1'b1, poly_x[i], poly_y[i], poly_z[i], 1'b0, lst);
                    continue;
                end
                push_split(poly_s[i] == SIDE_BACK, poly_x[i], poly_y[i], poly_z[i], 1'b0, lst);
                if (poly_s[j] == SIDE_ON || poly_s[j] == poly_s[i]) continue;
                di = poly_d[i];
                dj = poly_d[j];
                num = (di < 0) ? -di : di;
                den = (di - dj < 0) ? dj - di : di - dj;
                t = 0;
                // Restoring division for the crossing fraction.
                for (int b = 0; b < TW; b++) begin
                    num = num << 1;
                    t = t << 1;
                    if (num >= den) begin
                        num = num - den;
                        t = t | 1;
                    end
                end
                mx = cross_axis(plane_nx, poly_x[i], poly_x[j], t);
                my = cross_axis(plane_ny, poly_y[i], poly_y[j], t);
                mz = cross_axis(plane_nz, poly_z[i], poly_z[j], t);
                push_split(1'b0, mx, my, mz, 1'b1, lst);
                push_split(1'b1, mx, my, mz, 1'b1, lst);
            end
        end
        foreach (lst[r]) lst[r].overflow = saw_drop;
        if (lst.size() > 0) lst[lst.size() - 1].done_res = 1'b1;
        foreach (lst[r]) split_q.insert(split_q.size(), lst[r]);
        poly_n = 0;
        saw_front = 1'b0; saw_back = 1'b0; saw_drop = 1'b0;
    endfunction

    // Send one vertex request and wait until it is taken.
    task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
        int gap;
        vtx.valid <= 1'b1;
        vtx.x <= x; vtx.y <= y; vtx.z <= z; vtx.last <= last;
        do @(posedge i_clk); while (!vtx.ready);
        split_vertex(x, y, z, last);
        gap = pick_gap();
        if (gap > 0) begin
            vtx.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every expected result has come and the core settles.
    task automatic drain_results();
        vtx.valid <= 1'b0;
        while (split_q.size() > 0) @(posedge i_clk);
        repeat (SettleCyc) @(posedge i_clk);
    endtask

    // APB register write: setup cycle then access cycle.
    task automatic write_reg(t_reg idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= PAddrW'({idx, 2'b00}); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_NORMAL_X:     plane_nx = longint'(signed'(val[17:0]));
            REG_NORMAL_Y:     plane_ny = longint'(signed'(val[17:0]));
            REG_NORMAL_Z:     plane_nz = longint'(signed'(val[17:0]));
            REG_PLANE_OFFSET: plane_off = longint'(signed'(val));
            REG_EPSILON:      plane_eps = longint'(val[15:0]);
            default: ;
        endcase
    endtask

    task automatic set_plane(int nx, int ny, int nz, int off, int eps);
        write_reg(REG_NORMAL_X, nx);
        write_reg(REG_NORMAL_Y, ny);
        write_reg(REG_NORMAL_Z, nz);
        write_reg(REG_PLANE_OFFSET, off);
        write_reg(REG_EPSILON, eps);
    endtask

    // Directed polygons at the reset plane x = 0.
    task automatic test_reset_plane();
        // All front, all back, on-only, then a split with on vertices and extremes.
        send_vertex(32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_vertex(32'h7fff_ffff, 32'h0, 32'hffff_ffff, 1'b1);
        send_vertex(32'h8000_0000, 32'h1, 32'h2, 1'b0);
        send_vertex(32'hffff_ff00, 32'h3, 32'h4, 1'b1);
        send_vertex(32'd66, 32'h5, 32'h6, 1'b0);
        send_vertex(-32'sd66, 32'h7, 32'h8, 1'b1);
        send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_vertex(32'h0, 32'h1234_5678, 32'h0, 1'b0);
        send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_vertex(32'h0005_0000, 32'hffff_ffff, 32'h0, 1'b1);
        // Single vertex, and a polygon over capacity.
        send_vertex(32'h0002_0000, 32'h0, 32'h0, 1'b1);
        for (int i = 0; i < CapVerts + 3; i++)
            send_vertex((i % 2) ? 32'h0003_0000 : 32'hfffd_0000, i, -i,
                        i == CapVerts + 2);
        drain_results();
    endtask

    // Negative axial normal with the most negative offset, no on band.
    task automatic test_saturated_snap();
        set_plane(0, 0, -65536, 32'h8000_0000, 0);
        send_vertex(32'h1, 32'h2, 32'h7fff_0000, 1'b0);
        send_vertex(32'h3, 32'h4, 32'h8000_0000, 1'b0);
        send_vertex(32'h5, 32'h6, 32'h7fff_ffff, 1'b1);
        drain_results();
    endtask

    function automatic logic [31:0] rand_coord(int unsigned mode);
        if (mode == 0) return $urandom;
        if (mode == 1) return $urandom_range(32'h000f_ffff) - 32'h0008_0000;
        return $urandom_range(200) - 100;
    endfunction

    // Random polygons against one plane setting.
    task automatic test_random_polygons(int n_items);
        int sent, sz, mode;
        sent = 0;
        while (sent < n_items) begin
            sz = ($urandom_range(9) == 0) ? $urandom_range(CapVerts + 4, CapVerts - 1)
                                          : $urandom_range(8, 1);
            mode = $urandom_range(2);
            no_idle = ($urandom_range(3) == 0);
            for (int i = 0; i < sz; i++)
                send_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode), i == sz - 1);
            sent += sz;
        end
        no_idle = 1'b0;
        drain_results();
    endtask

    // Receiver stalls.
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            res.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            res.ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // Compare each result request with the oldest expectation.
    always @(posedge i_clk) begin
        t_split_vtx e;
        if (i_rst_n && res.valid && res.ready) begin
            if (split_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result request x=%h", res.out_x);
            end else begin
                e = split_q.pop_front();
                if (res.side !== e.side || res.out_x !== e.ox || res.out_y !== e.oy ||
                    res.out_z !== e.oz || res.is_new !== e.is_new ||
                    res.overflow !== e.overflow || res.done_res !== e.done_res) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp s=%b %h %h %h n=%b o=%b d=%b, got s=%b %h %h %h n=%b o=%b d=%b",
                                 e.side, e.ox, e.oy, e.oz, e.is_new, e.overflow, e.done_res,
                                 res.side, res.out_x, res.out_y, res.out_z, res.is_new,
                                 res.overflow, res.done_res);
                end
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        cycles = 0;
        mismatches = 0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        vtx.valid = 1'b0; vtx.x = '0; vtx.y = '0; vtx.z = '0; vtx.last = 1'b0;
        plane_nx = 65536; plane_ny = 0; plane_nz = 0; plane_off = 0; plane_eps = 66;
        poly_n = 0; saw_front = 1'b0; saw_back = 1'b0; saw_drop = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_plane();
        test_saturated_snap();
        set_plane(65536, 0, 0, 0, 66);
        test_random_polygons(36);
        set_plane(30000, -40000, 20000, $urandom, 65535);
        test_random_polygons(36);
        set_plane(-65536, 65536, -1, 32'h0000_8000, 0);
        test_random_polygons(36);
        set_plane($urandom_range(131072) - 65536, $urandom_range(131072) - 65536,
                  $urandom_range(131072) - 65536, $urandom_range(32'h0010_0000) - 32'h0008_0000,
                  $urandom_range(65535));
        test_random_polygons(36);
        if (mismatches == 0 && split_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
sv/cpps_pkg.sv
sv/cpps_ifs.sv
sv/cpps_ram.sv
sv/cpps_job_fifo.sv
sv/cpps_front.sv
sv/cpps_back.sv
sv/convex_polygon_plane_split_core.sv
sv/cpps_checker.sv
test/tb.sv
